// ===== rtl/hcls_pkg.sv =====
// ----------------------------------------------------------------------------
// hcls_pkg
// Shared constants, types and helpers for the http get classifier: header
// offsets, protocol codes, the request prefix and the verdict record.
// ----------------------------------------------------------------------------
package hcls_pkg;

	// fixed ethernet / ipv4 / tcp layout
	localparam int unsigned ETH_HDR_BYTES  = 14;
	localparam int unsigned POS_ETYPE_HI   = 12;
	localparam int unsigned POS_ETYPE_LO   = 13;
	localparam int unsigned POS_IHL        = 14;
	localparam int unsigned POS_TLEN_HI    = 16;
	localparam int unsigned POS_TLEN_LO    = 17;
	localparam int unsigned POS_PROTO      = 23;
	localparam int unsigned TCP_DOFF_BYTE  = 12;
	localparam int unsigned TCP_MIN_BYTES  = 20;
	localparam int unsigned MIN_PAYLOAD    = 7;
	localparam int unsigned PREFIX_LEN     = 4;

	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [7:0]  PROTO_TCP      = 8'd6;
	localparam logic [3:0]  MIN_HDR_WORDS  = 4'd5;

	// one verdict item
	typedef struct packed {
		logic is_ipv4_tcp;
		logic is_http_get;
	} verdict_t;

	// request prefix "GET "
	function automatic logic [7:0] prefix_char(input logic [1:0] idx);
		logic [7:0] c;
		case (idx)
			2'd0:    c = 8'h47;
			2'd1:    c = 8'h45;
			2'd2:    c = 8'h54;
			default: c = 8'h20;
		endcase
		return c;
	endfunction

endpackage

// ===== rtl/http_get_packet_classifier_unit.sv =====
// ----------------------------------------------------------------------------
// http_get_packet_classifier_unit
// Byte-serial ethernet frame classifier reporting ipv4/tcp and http get.
// ----------------------------------------------------------------------------
// Takes one frame byte per cycle, destination mac first, with last_byte on the
// final byte, and gives one verdict item per frame (is_ipv4_tcp, is_http_get)
// after that last byte. Throughput is one byte every cycle with no gaps between
// frames, but for the stall below. verdict_valid rises once the last byte has
// passed from the input register, through the combinational parse logic, into the
// verdict register. Input bytes keep flowing while a verdict waits to be taken;
// only a last byte stalls, when the previous verdict is still unclaimed. Frames
// longer than MAX_FRAME_BYTES are handled; the position count just saturates.
module http_get_packet_classifier_unit #(
	parameter int MAX_FRAME_BYTES = 16384
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	output logic       byte_ready,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	output logic       verdict_valid,
	input  logic       verdict_ready,
	output logic       is_ipv4_tcp,
	output logic       is_http_get
);
	import hcls_pkg::*;

	logic       valid_s1;
	logic [7:0] data_s1;
	logic       last_s1;
	logic       out_free;
	logic       fire;
	verdict_t   verdict;
	logic       out_valid_q;
	verdict_t   out_q;

	// a non-last byte never needs the verdict register
	assign out_free   = !out_valid_q || verdict_ready;
	assign fire       = valid_s1 && (out_free || !last_s1);
	assign byte_ready = !valid_s1 || fire;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ready && byte_valid) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	hcls_parser #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.data_byte (data_s1),
		.last_byte (last_s1),
		.verdict   (verdict)
	);

	// verdict register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (verdict_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && last_s1) begin
			out_q <= verdict;
		end
	end

	assign verdict_valid = out_valid_q;
	assign is_ipv4_tcp   = out_q.is_ipv4_tcp;
	assign is_http_get   = out_q.is_http_get;

	// a get verdict always implies an ipv4/tcp frame
	a_get_implies_tcp: assert property (@(posedge clk) disable iff (!arst_n)
		verdict_valid |-> (!is_http_get || is_ipv4_tcp))
		else $error("http get flagged on non tcp frame");

	// a processed last byte always loads a verdict
	a_last_loads_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		fire && last_s1 |=> verdict_valid)
		else $error("last byte produced no verdict");

	// input only stalls behind a held last byte
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!byte_ready |-> valid_s1 && last_s1 && out_valid_q && !verdict_ready)
		else $error("input stalled without a pending verdict");

endmodule

// ===== rtl/hcls_parser.sv =====
// ----------------------------------------------------------------------------
// hcls_parser
// Frame state and per-byte logic: header field captures, payload prefix
// match and the end-of-frame verdict. State advances on each processed byte
// and clears after the last byte of a frame.
// ----------------------------------------------------------------------------
module hcls_parser #(
	parameter int MAX_FRAME_BYTES = 16384
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  logic [7:0]          data_byte,
	input  logic                last_byte,
	output hcls_pkg::verdict_t  verdict
);
	import hcls_pkg::*;

	localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);
	localparam int CW    = 18;

	logic [POS_W-1:0] pos_q;
	logic [15:0]      etype_q;
	logic [3:0]       ihl_q;
	logic [7:0]       proto_q;
	logic [15:0]      tlen_q;
	logic [3:0]       doff_q;
	logic [2:0]       match_q;

	logic [15:0]      etype_d;
	logic [3:0]       ihl_d;
	logic [7:0]       proto_d;
	logic [15:0]      tlen_d;
	logic [3:0]       doff_d;
	logic [2:0]       match_d;

	logic [CW-1:0]    pos_x;
	logic [CW-1:0]    n_x;
	logic [CW-1:0]    tcp_start_old;
	logic [CW-1:0]    pay_off_old;
	logic [CW-1:0]    ihl4_new;
	logic [CW-1:0]    doff4_new;
	logic signed [CW-1:0] plen;
	logic             tcp_ok;
	logic             get_ok;

	assign pos_x = CW'(pos_q);
	assign n_x   = pos_x + CW'(1);

	// offsets from the state held before this byte
	assign tcp_start_old = CW'(ETH_HDR_BYTES) + CW'({ihl_q, 2'b00});
	assign pay_off_old   = tcp_start_old + CW'({doff_q, 2'b00});

	// header captures, applied in order
	always_comb begin
		etype_d = etype_q;
		ihl_d   = ihl_q;
		proto_d = proto_q;
		tlen_d  = tlen_q;
		doff_d  = doff_q;
		match_d = match_q;
		if (pos_x == CW'(POS_ETYPE_HI)) etype_d[15:8] = data_byte;
		if (pos_x == CW'(POS_ETYPE_LO)) etype_d[7:0]  = data_byte;
		if (pos_x == CW'(POS_IHL))      ihl_d         = data_byte[3:0];
		if (pos_x == CW'(POS_TLEN_HI))  tlen_d[15:8]  = data_byte;
		if (pos_x == CW'(POS_TLEN_LO))  tlen_d[7:0]   = data_byte;
		if (pos_x == CW'(POS_PROTO))    proto_d       = data_byte;
		if (ihl_d >= MIN_HDR_WORDS && pos_x == tcp_start_old + CW'(TCP_DOFF_BYTE))
			doff_d = data_byte[7:4];
		// payload prefix match, one expected byte at a time
		if (ihl_d >= MIN_HDR_WORDS && doff_d >= MIN_HDR_WORDS &&
		    match_q < 3'(PREFIX_LEN) && pos_x == pay_off_old + CW'(match_q)) begin
			if (data_byte == prefix_char(match_q[1:0]))
				match_d = match_q + 3'd1;
		end
	end

	// end-of-frame verdict from the updated fields
	assign ihl4_new  = CW'({ihl_d, 2'b00});
	assign doff4_new = CW'({doff_d, 2'b00});
	assign plen      = $signed(CW'(tlen_d)) - $signed(ihl4_new) - $signed(doff4_new);

	assign tcp_ok = (etype_d == ETHERTYPE_IPV4) && (ihl_d >= MIN_HDR_WORDS) &&
	                (proto_d == PROTO_TCP) &&
	                (n_x >= CW'(ETH_HDR_BYTES) + ihl4_new + CW'(TCP_MIN_BYTES));

	assign get_ok = tcp_ok && (doff_d >= MIN_HDR_WORDS) &&
	                (plen >= $signed(CW'(MIN_PAYLOAD))) &&
	                (n_x >= CW'(ETH_HDR_BYTES) + ihl4_new + doff4_new + CW'(MIN_PAYLOAD)) &&
	                (match_d == 3'(PREFIX_LEN));

	always_comb begin
		verdict.is_ipv4_tcp = tcp_ok;
		verdict.is_http_get = get_ok;
	end

	// frame state, cleared after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			etype_q <= '0;
			ihl_q   <= '0;
			proto_q <= '0;
			tlen_q  <= '0;
			doff_q  <= '0;
			match_q <= '0;
		end else if (fire) begin
			if (last_byte) begin
				pos_q   <= '0;
				etype_q <= '0;
				ihl_q   <= '0;
				proto_q <= '0;
				tlen_q  <= '0;
				doff_q  <= '0;
				match_q <= '0;
			end else begin
				if (pos_q < POS_W'(MAX_FRAME_BYTES))
					pos_q <= pos_q + POS_W'(1);
				etype_q <= etype_d;
				ihl_q   <= ihl_d;
				proto_q <= proto_d;
				tlen_q  <= tlen_d;
				doff_q  <= doff_d;
				match_q <= match_d;
			end
		end
	end

	// a processed last byte starts the next frame from position zero
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		fire && last_byte |=> pos_q == '0 && match_q == '0)
		else $error("frame state not cleared after last byte");

	// prefix counter never runs past the prefix length
	a_match_bound: assert property (@(posedge clk) disable iff (!arst_n)
		match_q <= 3'(PREFIX_LEN))
		else $error("prefix match count out of range");

	// position never passes the saturation point
	a_pos_sat: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_W'(MAX_FRAME_BYTES))
		else $error("byte position beyond saturation");

endmodule
